### hw/rtl/edid_pkg.sv
// ----------------------------------------------------------------------------
// edid_pkg
// shared types and constants of the edid base block parser
// ----------------------------------------------------------------------------
package edid_pkg;

  localparam int unsigned BlockLen = 128;
  localparam int unsigned DescBase = 54;
  localparam int unsigned DescLen  = 18;
  localparam int unsigned TextLen  = 13;

  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusShort  = 2'd1;
  localparam logic [1:0] StatusHeader = 2'd2;

  localparam logic [1:0] KindSummary = 2'd0;
  localparam logic [1:0] KindName    = 2'd1;
  localparam logic [1:0] KindIdent   = 2'd2;
  localparam logic [1:0] KindSerial  = 2'd3;

  typedef enum logic [2:0] {
    ST_CAPTURE,
    ST_SUMMARY,
    ST_BOUND,
    ST_TRIM,
    ST_CHARS
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       capture;   // accept byte into datapath
    logic       load_sum;  // load summary into output register
    logic       start_str; // begin bound scan of string sel
    logic       bound_step;
    logic       trim_step;
    logic       char_step; // emit one char or the terminator
    logic       clear;     // return to reset state
    logic [1:0] sel;       // string index 0..2
  } ctrl_t;

  // status from datapath to controller
  typedef struct packed {
    logic ok;          // length and header good
    logic bound_done;
    logic trim_done;
    logic str_done;    // terminator emitted
    logic out_full;    // output register holds a result not taken this cycle
  } stat_t;

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0b || c == 8'h0c;
  endfunction

  function automatic logic is_cut(input logic [7:0] c);
    return c == 8'h00 || c == 8'h0d || c == 8'h0a;
  endfunction

endpackage

### hw/rtl/edid_ctrl.sv
// ----------------------------------------------------------------------------
// edid_ctrl
// sequencer: byte capture, then summary and string emission
// ----------------------------------------------------------------------------
module edid_ctrl
  import edid_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_fire,
  input  logic  in_last,
  input  stat_t stat,
  output ctrl_t ctrl,
  output logic  in_ready
);

  state_t     state, state_next;
  logic [1:0] sel, sel_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CAPTURE;
      sel   <= 2'd0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    sel_next   = sel;
    case (state)
      ST_CAPTURE: if (in_fire && in_last) state_next = ST_SUMMARY;
      ST_SUMMARY: begin
        if (!stat.out_full) begin
          sel_next   = 2'd0;
          state_next = stat.ok ? ST_BOUND : ST_CAPTURE;
        end
      end
      ST_BOUND: if (stat.bound_done) state_next = ST_TRIM;
      ST_TRIM:  if (stat.trim_done) state_next = ST_CHARS;
      ST_CHARS: begin
        if (stat.str_done) begin
          if (sel == 2'd2) state_next = ST_CAPTURE;
          else begin
            sel_next   = sel + 2'd1;
            state_next = ST_BOUND;
          end
        end
      end
      default: state_next = ST_CAPTURE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl     = '0;
    ctrl.sel = sel;
    in_ready = 1'b0;
    case (state)
      ST_CAPTURE: begin
        in_ready     = 1'b1;
        ctrl.capture = in_fire;
      end
      ST_SUMMARY: begin
        ctrl.load_sum  = !stat.out_full;
        ctrl.start_str = !stat.out_full;
        ctrl.clear     = !stat.out_full && !stat.ok;
      end
      ST_BOUND: ctrl.bound_step = 1'b1;
      ST_TRIM:  ctrl.trim_step = 1'b1;
      ST_CHARS: begin
        ctrl.char_step = 1'b1;
        ctrl.clear     = stat.str_done && sel == 2'd2;
        ctrl.start_str = stat.str_done;
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/edid_dp.sv
// ----------------------------------------------------------------------------
// edid_dp
// capture registers, text memory, trim scan and output register
// ----------------------------------------------------------------------------
module edid_dp
  import edid_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ctrl_t       ctrl,
  input  logic [7:0]  in_byte,
  input  logic        out_take,
  output stat_t       stat,
  output logic        out_valid,
  output logic [1:0]  o_status,
  output logic [1:0]  o_kind,
  output logic [6:0]  o_pnp1,
  output logic [6:0]  o_pnp2,
  output logic [6:0]  o_pnp3,
  output logic [15:0] o_product,
  output logic [31:0] o_serial,
  output logic [7:0]  o_width,
  output logic [7:0]  o_height,
  output logic [7:0]  o_char,
  output logic [3:0]  o_pos,
  output logic        o_last
);

  logic [7:0]  byte_count;
  logic        header_match;
  logic [15:0] vendor_bytes, product_reg, size_bytes;
  logic [31:0] serial_reg;
  logic [1:0]  descriptor_kind;
  logic [2:0]  scan_flags;
  logic [2:0]  text_valid;
  logic [7:0]  text_store [3*TextLen];
  logic [4:0]  doff;       // offset within current descriptor
  logic [2:0]  dcount;     // descriptors passed

  // scan registers
  logic [3:0]  idx;        // memory read index within string
  logic [3:0]  len, first, stop, pos;
  logic        phase;      // 0 issue read, 1 data ready
  logic [7:0]  rdata;
  logic [5:0]  raddr;

  logic [7:0]  head_pat;
  logic [7:0]  p;
  logic        full;
  logic        in_desc;
  logic [5:0]  waddr;

  assign p       = byte_count;
  assign full    = byte_count[7];
  assign in_desc = p >= 8'(DescBase) && dcount < 3'd4 && !full;
  assign waddr   = 6'(({4'd0, descriptor_kind} - 6'd1) * 6'(TextLen)) + 6'(doff - 5'd5);
  assign raddr   = 6'({4'd0, ctrl.sel} * 6'(TextLen)) + 6'(idx);

  always_comb begin
    case (p[2:0])
      3'd0, 3'd7: head_pat = 8'h00;
      default:    head_pat = 8'hff;
    endcase
  end

  // text memory
  always_ff @(posedge clk) begin
    if (ctrl.capture && in_desc && doff >= 5'd5 && descriptor_kind != 2'd0)
      text_store[waddr] <= in_byte;
    rdata <= text_store[raddr];
  end

  // capture
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      byte_count      <= '0;
      header_match    <= 1'b1;
      vendor_bytes    <= '0;
      product_reg     <= '0;
      serial_reg      <= '0;
      size_bytes      <= '0;
      descriptor_kind <= '0;
      scan_flags      <= '0;
      text_valid      <= '0;
      doff            <= '0;
      dcount          <= '0;
    end else if (ctrl.capture && !full) begin
      byte_count <= byte_count + 8'd1;
      if (p < 8'd8 && in_byte != head_pat) header_match <= 1'b0;
      case (p)
        8'd8:  vendor_bytes[7:0]  <= in_byte;
        8'd9:  vendor_bytes[15:8] <= in_byte;
        8'd10: product_reg[7:0]   <= in_byte;
        8'd11: product_reg[15:8]  <= in_byte;
        8'd12: serial_reg[7:0]    <= in_byte;
        8'd13: serial_reg[15:8]   <= in_byte;
        8'd14: serial_reg[23:16]  <= in_byte;
        8'd15: serial_reg[31:24]  <= in_byte;
        8'd21: size_bytes[7:0]    <= in_byte;
        8'd22: size_bytes[15:8]   <= in_byte;
        default: ;
      endcase
      if (in_desc) begin
        if (doff == 5'(DescLen - 1)) begin
          doff   <= '0;
          dcount <= dcount + 3'd1;
        end else doff <= doff + 5'd1;
        case (doff)
          5'd0: begin
            descriptor_kind <= '0;
            scan_flags      <= {2'b00, in_byte == 8'h00};
          end
          5'd1: if (in_byte == 8'h00) scan_flags[1] <= 1'b1;
          5'd2: if (in_byte == 8'h00) scan_flags[2] <= 1'b1;
          5'd3: begin
            descriptor_kind <= KindSummary;
            if (scan_flags == 3'b111) begin
              if (in_byte == 8'hfc)      descriptor_kind <= KindName;
              else if (in_byte == 8'hfe) descriptor_kind <= KindIdent;
              else if (in_byte == 8'hff) descriptor_kind <= KindSerial;
            end
          end
          default: begin
            if (doff >= 5'd5 && descriptor_kind != 2'd0)
              text_valid[descriptor_kind - 2'd1] <= 1'b1;
          end
        endcase
      end
    end
  end

  logic ok;
  assign ok = full && header_match;

  // string scans: find cut length, then leading blanks, then trailing blanks
  logic [7:0] ch;
  logic       char_fire;
  assign ch = rdata;
  assign char_fire = ctrl.char_step && phase && (!out_valid || out_take);

  always_ff @(posedge clk) begin
    if (rst || ctrl.start_str) begin
      idx   <= '0;
      len   <= '0;
      phase <= 1'b0;
      first <= '0;
      stop  <= '0;
      pos   <= '0;
    end else if (ctrl.bound_step) begin
      if (!text_valid[ctrl.sel]) begin
        len <= '0;
        idx <= '0;
      end else if (!phase) phase <= 1'b1;
      else if (is_cut(ch) || idx == 4'(TextLen)) begin
        phase <= 1'b0;
        idx   <= '0;
      end else begin
        len   <= len + 4'd1;
        idx   <= idx + 4'd1;
        phase <= 1'b0;
      end
    end else if (ctrl.trim_step) begin
      // first scans upward, then stop scans downward
      if (!phase) phase <= 1'b1;
      else if (first < len && is_blank(ch) && idx == first) begin
        first <= first + 4'd1;
        idx   <= first + 4'd1;
        phase <= 1'b0;
      end else if (idx <= first || idx == len) begin
        // leading done: move to trailing scan from len-1
        if (stop == 4'd0 && len > first) begin
          stop  <= len;
          idx   <= len - 4'd1;
          phase <= 1'b0;
        end else begin
          phase <= 1'b0;
          idx   <= first;
        end
      end else if (stop > first && is_blank(ch)) begin
        stop  <= stop - 4'd1;
        idx   <= idx - 4'd1;
        phase <= 1'b0;
      end else begin
        phase <= 1'b0;
        idx   <= first;
      end
    end else if (ctrl.char_step) begin
      if (!phase) phase <= 1'b1;
      else if (char_fire) begin
        phase <= 1'b0;
        idx   <= idx + 4'd1;
        pos   <= pos + 4'd1;
      end
    end
  end

  // bound and trim completion flags
  logic bound_done, trim_done;
  assign bound_done = ctrl.bound_step &&
    (!text_valid[ctrl.sel] || (phase && (is_cut(ch) || idx == 4'(TextLen))));
  assign trim_done = ctrl.trim_step && phase &&
    !(first < len && is_blank(ch) && idx == first) &&
    (idx <= first || idx == len ? !(stop == 4'd0 && len > first)
                                : !(stop > first && is_blank(ch)));

  logic at_term;
  assign at_term = (stop <= first) || (idx >= stop);

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (ctrl.load_sum || char_fire) out_valid <= 1'b1;
    else if (out_take) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_sum) begin
      o_status  <= !full ? StatusShort : (!header_match ? StatusHeader : StatusOk);
      o_kind    <= KindSummary;
      o_pnp1    <= ok ? 7'h40 + 7'(vendor_bytes[6:2]) : '0;
      o_pnp2    <= ok ? 7'h40 + 7'({vendor_bytes[1:0], vendor_bytes[15:13]}) : '0;
      o_pnp3    <= ok ? 7'h40 + 7'(vendor_bytes[12:8]) : '0;
      o_product <= ok ? product_reg : '0;
      o_serial  <= ok ? serial_reg : '0;
      o_width   <= ok ? size_bytes[7:0] : '0;
      o_height  <= ok ? size_bytes[15:8] : '0;
      o_char    <= '0;
      o_pos     <= '0;
      o_last    <= !ok;
    end else if (char_fire) begin
      o_status  <= StatusOk;
      o_kind    <= ctrl.sel + 2'd1;
      o_pnp1    <= '0;
      o_pnp2    <= '0;
      o_pnp3    <= '0;
      o_product <= '0;
      o_serial  <= '0;
      o_width   <= '0;
      o_height  <= '0;
      o_char    <= at_term ? 8'h00 : ch;
      o_pos     <= at_term ? (stop > first ? stop - first : 4'd0) : pos;
      o_last    <= at_term && ctrl.sel == 2'd2;
    end
  end

  assign stat.ok         = ok;
  assign stat.bound_done = bound_done;
  assign stat.trim_done  = trim_done;
  assign stat.str_done   = char_fire && at_term;
  assign stat.out_full   = out_valid && !out_take;

endmodule

### hw/rtl/edid_base_block_parser_unit.sv
// ----------------------------------------------------------------------------
// edid_base_block_parser_unit
// edid 1.3 base block parser with summary and string emission
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle from offset 0 while capturing. The byte with
// tlast set ends the buffer; input then stalls while one summary transfer is
// sent, followed per string by a bound scan and a trim scan over the 39-byte
// text memory (each byte read is issued, then its data checked) and then one
// transfer per character plus a terminator. A failed buffer gives a single
// summary with zeroed fields, its error status and last_result set.
// tuser on the output carries record_kind.
module edid_base_block_parser_unit
  import edid_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tlast,   // end_of_block
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[1:0], pnp_first[8:2], pnp_second[15:9], pnp_third[22:16],
  // product_code[38:23], serial_value[70:39], width_cm[78:71],
  // height_cm[86:79], text_char[94:87], text_pos[98:95], zero fill
  output logic [103:0] m_tdata,
  output logic [1:0]  m_tuser,   // record_kind
  output logic        m_tlast    // last_result
);

  ctrl_t ctrl;
  stat_t stat;
  logic  in_fire;
  logic [1:0]  o_status;
  logic [6:0]  o_pnp1, o_pnp2, o_pnp3;
  logic [15:0] o_product;
  logic [31:0] o_serial;
  logic [7:0]  o_width, o_height, o_char;
  logic [3:0]  o_pos;

  assign in_fire = s_tvalid && s_tready;

  edid_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_last(s_tlast),
    .stat(stat), .ctrl(ctrl), .in_ready(s_tready)
  );

  edid_dp u_dp (
    .clk(clk), .rst(rst), .ctrl(ctrl), .in_byte(s_tdata),
    .out_take(m_tvalid && m_tready), .stat(stat), .out_valid(m_tvalid),
    .o_status(o_status), .o_kind(m_tuser), .o_pnp1(o_pnp1), .o_pnp2(o_pnp2),
    .o_pnp3(o_pnp3), .o_product(o_product), .o_serial(o_serial),
    .o_width(o_width), .o_height(o_height), .o_char(o_char), .o_pos(o_pos),
    .o_last(m_tlast)
  );

  assign m_tdata = {5'd0, o_pos, o_char, o_height, o_width, o_serial,
                    o_product, o_pnp3, o_pnp2, o_pnp1, o_status};

endmodule
